[rtl/assert_macros.svh]
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AST_SAME(label, clk, rst_n, ante, cons)
`define AST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/smftl_pkg.sv]
package smftl_pkg;

	localparam logic [2:0] CMD_READ      = 3'd0;
	localparam logic [2:0] CMD_PROGRAM   = 3'd1;
	localparam logic [2:0] CMD_TO_SPARE  = 3'd2;
	localparam logic [2:0] CMD_COPY_BACK = 3'd3;
	localparam logic [2:0] CMD_ERASE     = 3'd4;
	localparam logic [2:0] CMD_UNMAPPED  = 3'd5;

	localparam logic [1:0] PS_FREE    = 2'd0;
	localparam logic [1:0] PS_VALID   = 2'd1;
	localparam logic [1:0] PS_GARBAGE = 2'd2;

	localparam int SECTOR_LIMIT = 64;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_SCAN,
		OP_EMIT_RD,
		OP_COL_BEST,
		OP_COL_OWN,
		OP_COL_EVAL,
		OP_ERASE_VIC,
		OP_COPY_BACK,
		OP_ERASE_SPARE,
		OP_OLD_GARBAGE,
		OP_PROGRAM
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_ctl_t;

	typedef struct packed {
		logic clear_done;
		logic scan_done;
		logic found;
		logic has_garbage;
		logic map_hit;
		logic in_range;
		logic is_write;
		logic col_last;
	} dp_stat_t;

endpackage

[rtl/smftl_dp.sv]
module smftl_dp import smftl_pkg::*; #(
	parameter int PAGES_IN_BLOCK = 4,
	parameter int DATA_BLOCK_COUNT = 16,
	parameter int HOST_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_ctl_t    ctl,
	output dp_stat_t   stat,
	input  logic       opcode,
	input  logic [5:0] logical_sector,
	input  logic [3:0] buffer_slot,
	output logic       strobe,
	output logic [2:0] command,
	output logic [5:0] physical_page,
	output logic [1:0] spare_offset,
	output logic [4:0] block_number,
	output logic [5:0] owner_sector,
	output logic [3:0] buffer_slot_out,
	output logic       last
);

	localparam int TOTAL = PAGES_IN_BLOCK * DATA_BLOCK_COUNT;
	localparam int SECTOR_COUNT = (TOTAL < SECTOR_LIMIT) ? TOTAL : SECTOR_LIMIT;
	localparam int PW = $clog2(TOTAL);
	localparam int BW = $clog2(DATA_BLOCK_COUNT);
	localparam int JW = $clog2(PAGES_IN_BLOCK);
	localparam int CW = $clog2(PAGES_IN_BLOCK + 1);
	localparam logic [PW-1:0] LAST_PAGE = PW'(TOTAL - 1);
	localparam logic [BW-1:0] LAST_BLK = BW'(DATA_BLOCK_COUNT - 1);
	localparam logic [JW-1:0] LAST_J = JW'(PAGES_IN_BLOCK - 1);
	localparam logic [PW-1:0] PIB = PW'(PAGES_IN_BLOCK);

	function automatic logic [PW-1:0] page_of(input logic [BW-1:0] b, input logic [JW-1:0] j);
		page_of = PW'(PW'(b) * PIB + PW'(j));
	endfunction

	// sector map: block and in-block index, valid bits in flops
	logic [BW+JW-1:0] map_mem [SECTOR_LIMIT];
	logic [SECTOR_LIMIT-1:0] map_valid_q;
	logic [BW+JW-1:0] map_rd_q;
	logic [1:0] ps_mem [TOTAL];
	logic [1:0] ps_rd_q;

	logic       opc_q;
	logic [5:0] lsn_q;
	logic [3:0] slot_q;
	logic [3:0] slot_tab [16];

	logic [PW-1:0] addr_q;
	logic [BW-1:0] sblk_q, blk_s1, best_q, vic_q, fp_blk_q;
	logic [JW-1:0] sj_q, j_s1, j_q, drop_j_q, fj_q, fp_j_q;
	logic iss_done_q, scan_v_s1, found_q, drop_en_q, freed_q;
	logic [CW-1:0] cnt_q, max_q, cnt_n;

	logic issuing;
	logic [PW-1:0] ps_raddr, ps_waddr, col_page;
	logic [1:0] ps_wdata;
	logic ps_we, map_we, col_free;

	genvar gi;
	generate
		for (gi = 0; gi < 16; gi++) begin : g_slot
			assign slot_tab[gi] = 4'(gi % HOST_SLOTS);
		end
	endgenerate

	assign issuing  = (ctl.op == OP_SCAN) && !iss_done_q;
	assign col_page = page_of(vic_q, j_q);
	assign ps_raddr = (ctl.op == OP_SCAN) ? addr_q : col_page;
	assign cnt_n    = ((j_s1 == '0) ? '0 : cnt_q) + CW'(ps_rd_q == PS_GARBAGE);
	assign col_free = (drop_en_q && j_q == drop_j_q) || ps_rd_q == PS_GARBAGE;

	always_comb begin
		ps_we = 1'b0;
		ps_waddr = col_page;
		ps_wdata = PS_FREE;
		map_we = 1'b0;
		case (ctl.op)
			OP_CLEAR: begin
				ps_we = 1'b1;
				ps_waddr = addr_q;
			end
			OP_COL_EVAL: ps_we = col_free;
			OP_OLD_GARBAGE: begin
				ps_we = map_valid_q[lsn_q];
				ps_waddr = page_of(map_rd_q[BW+JW-1:JW], map_rd_q[JW-1:0]);
				ps_wdata = PS_GARBAGE;
			end
			OP_PROGRAM: begin
				ps_we = 1'b1;
				ps_waddr = page_of(fp_blk_q, fp_j_q);
				ps_wdata = PS_VALID;
				map_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ps_we) begin
			ps_mem[ps_waddr] <= ps_wdata;
		end
		ps_rd_q <= ps_mem[ps_raddr];
		if (map_we) begin
			map_mem[lsn_q] <= {fp_blk_q, fp_j_q};
		end
		map_rd_q <= map_mem[lsn_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= '0;
			addr_q <= '0;
			iss_done_q <= 1'b0;
			scan_v_s1 <= 1'b0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			scan_v_s1 <= issuing;
			case (ctl.op)
				OP_CLEAR: addr_q <= addr_q + 1'b1;
				OP_LOAD: begin
					addr_q <= '0;
					iss_done_q <= 1'b0;
				end
				OP_SCAN: begin
					if (issuing) begin
						addr_q <= addr_q + 1'b1;
						iss_done_q <= (addr_q == LAST_PAGE);
					end
				end
				OP_COL_OWN: map_valid_q[lsn_q] <= 1'b0;
				OP_PROGRAM: map_valid_q[lsn_q] <= 1'b1;
				default: ;
			endcase
			if (ctl.op == OP_EMIT_RD || ctl.op == OP_COL_EVAL && col_free == 1'b0
				&& ps_rd_q == PS_VALID || ctl.op == OP_ERASE_VIC
				|| ctl.op == OP_COPY_BACK || ctl.op == OP_ERASE_SPARE
				|| ctl.op == OP_PROGRAM) begin
				strobe <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				opc_q <= opcode;
				lsn_q <= logical_sector;
				slot_q <= slot_tab[buffer_slot];
				sblk_q <= '0;
				sj_q <= '0;
				found_q <= 1'b0;
				max_q <= '0;
				best_q <= '0;
				cnt_q <= '0;
			end
			OP_COL_BEST, OP_COL_OWN: begin
				vic_q <= (ctl.op == OP_COL_OWN) ? map_rd_q[BW+JW-1:JW] : best_q;
				drop_en_q <= (ctl.op == OP_COL_OWN);
				drop_j_q <= map_rd_q[JW-1:0];
				j_q <= '0;
				freed_q <= 1'b0;
			end
			OP_COL_EVAL, OP_COPY_BACK: begin
				j_q <= (j_q == LAST_J) ? '0 : j_q + 1'b1;
				if (ctl.op == OP_COL_EVAL && col_free && !freed_q) begin
					freed_q <= 1'b1;
					fj_q <= j_q;
				end
			end
			OP_ERASE_VIC: begin
				fp_blk_q <= vic_q;
				fp_j_q <= fj_q;
			end
			default: ;
		endcase
		if (issuing) begin
			blk_s1 <= sblk_q;
			j_s1 <= sj_q;
			sj_q <= (sj_q == LAST_J) ? '0 : sj_q + 1'b1;
			if (sj_q == LAST_J) begin
				sblk_q <= sblk_q + 1'b1;
			end
		end
		if (scan_v_s1 && ctl.op == OP_SCAN) begin
			if (ps_rd_q == PS_FREE && !found_q) begin
				found_q <= 1'b1;
				fp_blk_q <= blk_s1;
				fp_j_q <= j_s1;
			end
			cnt_q <= cnt_n;
			if (j_s1 == LAST_J && cnt_n > max_q) begin
				max_q <= cnt_n;
				best_q <= blk_s1;
			end
		end

		command <= CMD_READ;
		physical_page <= '0;
		spare_offset <= '0;
		block_number <= '0;
		owner_sector <= '0;
		buffer_slot_out <= '0;
		last <= 1'b0;
		case (ctl.op)
			OP_EMIT_RD: begin
				last <= 1'b1;
				if (stat.in_range && stat.map_hit) begin
					physical_page <= 6'(page_of(map_rd_q[BW+JW-1:JW], map_rd_q[JW-1:0]));
					buffer_slot_out <= slot_q;
				end else begin
					command <= CMD_UNMAPPED;
				end
			end
			OP_COL_EVAL: begin
				command <= CMD_TO_SPARE;
				physical_page <= 6'(col_page);
				spare_offset <= 2'(j_q);
			end
			OP_ERASE_VIC: begin
				command <= CMD_ERASE;
				block_number <= 5'(vic_q);
			end
			OP_COPY_BACK: begin
				command <= CMD_COPY_BACK;
				physical_page <= 6'(col_page);
				spare_offset <= 2'(j_q);
			end
			OP_ERASE_SPARE: begin
				command <= CMD_ERASE;
				block_number <= 5'(DATA_BLOCK_COUNT);
			end
			OP_PROGRAM: begin
				command <= CMD_PROGRAM;
				physical_page <= 6'(page_of(fp_blk_q, fp_j_q));
				owner_sector <= lsn_q;
				buffer_slot_out <= slot_q;
				last <= 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.clear_done  = (addr_q == LAST_PAGE);
		stat.scan_done   = scan_v_s1 && blk_s1 == LAST_BLK && j_s1 == LAST_J;
		stat.found       = found_q;
		stat.has_garbage = (max_q != '0);
		stat.map_hit     = map_valid_q[lsn_q];
		stat.in_range    = (7'(lsn_q) < 7'(SECTOR_COUNT));
		stat.is_write    = opc_q;
		stat.col_last    = (j_q == LAST_J);
	end

endmodule

[rtl/smftl_ctrl.sv]
module smftl_ctrl import smftl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MAPRD, S_READ_OUT, S_SCAN, S_DECIDE, S_COL_RD, S_COL_EV,
		S_ERASE_V, S_CB, S_ERASE_S, S_OLD, S_PROG
	} state_t;

	state_t state_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl.op = OP_NONE;
		case (state_q)
			S_CLEAR:    ctl.op = OP_CLEAR;
			S_IDLE:     ctl.op = start ? OP_LOAD : OP_NONE;
			S_READ_OUT: ctl.op = OP_EMIT_RD;
			S_SCAN:     ctl.op = OP_SCAN;
			S_DECIDE: begin
				if (!stat.found) begin
					ctl.op = stat.has_garbage ? OP_COL_BEST :
						(stat.map_hit ? OP_COL_OWN : OP_NONE);
				end
			end
			S_COL_EV:   ctl.op = OP_COL_EVAL;
			S_ERASE_V:  ctl.op = OP_ERASE_VIC;
			S_CB:       ctl.op = OP_COPY_BACK;
			S_ERASE_S:  ctl.op = OP_ERASE_SPARE;
			S_OLD:      ctl.op = OP_OLD_GARBAGE;
			S_PROG:     ctl.op = OP_PROGRAM;
			default:    ctl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR:    if (stat.clear_done) state_q <= S_IDLE;
				S_IDLE:     if (start) state_q <= S_MAPRD;
				S_MAPRD: begin
					if (!stat.is_write) begin
						state_q <= S_READ_OUT;
					end else begin
						state_q <= stat.in_range ? S_SCAN : S_IDLE;
					end
				end
				S_READ_OUT: state_q <= S_IDLE;
				S_SCAN:     if (stat.scan_done) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (stat.found) begin
						state_q <= S_OLD;
					end else if (stat.has_garbage || stat.map_hit) begin
						state_q <= S_COL_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_COL_RD:   state_q <= S_COL_EV;
				S_COL_EV:   state_q <= stat.col_last ? S_ERASE_V : S_COL_RD;
				S_ERASE_V:  state_q <= S_CB;
				S_CB:       if (stat.col_last) state_q <= S_ERASE_S;
				S_ERASE_S:  state_q <= S_OLD;
				S_OLD:      state_q <= S_PROG;
				S_PROG:     state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/sector_mapped_ftl_with_greedy_gc.sv]
// Sector-mapped flash translation layer. A request is taken when start is high and busy
// is low; it yields flash command words (none for a write that is out of range or finds
// no free page and nothing to collect), each shown for one cycle with strobe high and
// last high on the final one. The receiver cannot stall, so every word must be taken as
// it appears. A write scans every page state through one memory read port, and a write
// that finds no free page may run garbage collection first. After reset busy stays high
// while the page state memory is cleared.
`include "assert_macros.svh"
module sector_mapped_ftl_with_greedy_gc import smftl_pkg::*; #(
	parameter int PAGES_IN_BLOCK = 4,
	parameter int DATA_BLOCK_COUNT = 16,
	parameter int HOST_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       opcode,
	input  logic [5:0] logical_sector,
	input  logic [3:0] buffer_slot,
	output logic       strobe,
	output logic [2:0] command,
	output logic [5:0] physical_page,
	output logic [1:0] spare_offset,
	output logic [4:0] block_number,
	output logic [5:0] owner_sector,
	output logic [3:0] buffer_slot_out,
	output logic       last
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	smftl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .stat(stat), .ctl(ctl)
	);

	smftl_dp #(
		.PAGES_IN_BLOCK(PAGES_IN_BLOCK),
		.DATA_BLOCK_COUNT(DATA_BLOCK_COUNT),
		.HOST_SLOTS(HOST_SLOTS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .stat(stat),
		.opcode(opcode), .logical_sector(logical_sector), .buffer_slot(buffer_slot),
		.strobe(strobe), .command(command), .physical_page(physical_page),
		.spare_offset(spare_offset), .block_number(block_number),
		.owner_sector(owner_sector), .buffer_slot_out(buffer_slot_out), .last(last)
	);

	`AST_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`AST_SAME(a_idle_word_last, clk, arst_n, strobe && !busy, last)
	`AST_NEXT(a_last_gap, clk, arst_n, strobe && last, !strobe)

endmodule
